### rtl/fur_pkg.sv
// Shared types, constants and CRC helper functions of the firmware update receiver.
`default_nettype none

package fur_pkg;

  // Chunk geometry and limits
  localparam int unsigned MaxChunkBytes = 16;
  localparam int unsigned AddrW         = 24;
  localparam int unsigned CountW        = 5;
  localparam int unsigned ChunksW       = 14;

  localparam logic [31:0]        CrcPoly    = 32'hEDB8_8320;
  localparam logic [31:0]        CrcStart   = 32'hFFFF_FFFE;
  localparam logic [11:0]        SectorMask = 12'hFFF;
  localparam logic [ChunksW-1:0] LimitLong  = 14'h3FFF;
  localparam logic [ChunksW-1:0] LimitShort = 14'h0FFF;
  localparam logic [7:0]         PatchMatch = 8'h4B;  // ASCII 'K'
  localparam logic [7:0]         PatchValue = 8'hFF;
  localparam logic [CountW-1:0]  LongChunk  = 5'd16;
  localparam logic [CountW-1:0]  ShortChunk = 5'd4;
  localparam logic [7:0]         BankLimit  = 8'd3;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_BANK   = 2'd1,
    OP_CHUNK  = 2'd2,
    OP_COMMIT = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    RK_NONE        = 3'd0,
    RK_SESSION_ACK = 3'd1,
    RK_CHUNK_ACK   = 3'd2,
    RK_REFUSED     = 3'd3,
    RK_BANK_REPLY  = 3'd4,
    RK_COMMIT      = 3'd5
  } reply_kind_e;

  typedef struct packed {
    op_e         operation;
    logic [7:0]  seq_in;
    logic [7:0]  bank_request;
    logic [4:0]  chunk_count;
    logic [63:0] chunk_low;
    logic [63:0] chunk_high;
    logic [31:0] crc_first;
    logic [31:0] crc_second;
  } in_item_t;

  typedef struct packed {
    reply_kind_e reply_kind;
    logic [7:0]  seq_out;
    logic        bank_ok;
    logic        commit_fail;
    logic        erase_now;
    logic        program_now;
    logic [23:0] flash_address;
    logic [4:0]  program_count;
    logic [63:0] program_low;
    logic [63:0] program_high;
    logic        image_done;
  } out_item_t;

  // One reflected CRC step over a whole byte, from a zero register
  function automatic logic [31:0] crc_spread_f(input logic [31:0] v_in);
    logic [31:0] v;
    v = v_in;
    for (int b = 0; b < 8; b++) begin
      v = v[0] ? ((v >> 1) ^ CrcPoly) : (v >> 1);
    end
    return v;
  endfunction

  // Slicing basis: contribution of bit j of a byte followed by k zero bytes.
  // Only called with constant arguments.
  function automatic logic [31:0] crc_basis_f(input int unsigned k, input int unsigned j);
    logic [31:0] v;
    v = crc_spread_f(32'(1) << j);
    for (int unsigned z = 0; z < k; z++) begin
      v = (v >> 8) ^ crc_spread_f({24'd0, v[7:0]});
    end
    return v;
  endfunction

endpackage

`default_nettype wire

### rtl/fur_crc_lane.sv
// One CRC byte lane: contribution of its byte to the chunk's CRC by position.
`default_nettype none

module fur_crc_lane #(
  parameter int unsigned LANE = 0
) (
  input  logic [7:0]  lane_byte_i,
  input  logic [4:0]  chunk_count_i,
  output logic [31:0] contrib_o
);
  import fur_pkg::*;

  localparam logic [CountW-1:0] LaneNext = CountW'(LANE + 1);

  logic [31:0] basis_w [MaxChunkBytes][8];
  logic [3:0]  trail_w;
  logic        active_w;
  logic [31:0] acc_w;

  // Constant basis, folded at elaboration
  for (genvar k = 0; k < MaxChunkBytes; k++) begin : g_tail
    for (genvar j = 0; j < 8; j++) begin : g_bit
      assign basis_w[k][j] = crc_basis_f(k, j);
    end
  end

  // Zero bytes that follow this lane's byte within the chunk
  assign active_w = (chunk_count_i >= LaneNext);
  assign trail_w  = 4'(chunk_count_i - LaneNext);

  always_comb begin
    acc_w = '0;
    for (int j = 0; j < 8; j++) begin
      if (lane_byte_i[j]) begin
        acc_w = acc_w ^ basis_w[trail_w][j];
      end
    end
  end

  assign contrib_o = active_w ? acc_w : '0;

endmodule

`default_nettype wire

### rtl/fur_crc_unit.sv
// Sixteen CRC lanes and the XOR merge that gives the CRC after a whole chunk.
`default_nettype none

module fur_crc_unit (
  input  logic [31:0] crc_i,
  input  logic [63:0] chunk_low_i,
  input  logic [63:0] chunk_high_i,
  input  logic [4:0]  chunk_count_i,
  output logic [31:0] crc_o
);
  import fur_pkg::*;

  logic [7:0]  lane_byte_w [MaxChunkBytes];
  logic [31:0] contrib_w   [MaxChunkBytes];
  logic [31:0] carry_w;
  logic [31:0] merge_w;

  // The low four bytes fold in the running register
  for (genvar i = 0; i < MaxChunkBytes; i++) begin : g_lane
    if (i < 4) begin : g_head
      assign lane_byte_w[i] = chunk_low_i[8*i +: 8] ^ crc_i[8*i +: 8];
    end else if (i < 8) begin : g_low
      assign lane_byte_w[i] = chunk_low_i[8*i +: 8];
    end else begin : g_high
      assign lane_byte_w[i] = chunk_high_i[8*(i-8) +: 8];
    end

    fur_crc_lane #(
      .LANE(i)
    ) u_lane (
      .lane_byte_i  (lane_byte_w[i]),
      .chunk_count_i(chunk_count_i),
      .contrib_o    (contrib_w[i])
    );
  end

  // Register bits not consumed by a short chunk shift through
  always_comb begin
    unique case (chunk_count_i)
      5'd0:    carry_w = crc_i;
      5'd1:    carry_w = crc_i >> 8;
      5'd2:    carry_w = crc_i >> 16;
      5'd3:    carry_w = crc_i >> 24;
      default: carry_w = '0;
    endcase
  end

  // Merge
  always_comb begin
    merge_w = carry_w;
    for (int i = 0; i < MaxChunkBytes; i++) begin
      merge_w = merge_w ^ contrib_w[i];
    end
  end

  assign crc_o = merge_w;

endmodule

`default_nettype wire

### rtl/firmware_update_receiver.sv
// Top level of the firmware update receiver: session control, flash commands, output stage.
`default_nettype none

// Takes one command transaction per clock while in_ready_o is high and returns exactly one
// reply transaction for each through the output register. A data chunk of up to sixteen
// bytes updates the running CRC-32 on acceptance while bank 0 is active: sixteen byte lanes
// each compute their byte's share of the CRC and an XOR merge combines them. The output
// register is backed by a one-entry skid stage, so a new transaction is still taken while a
// reply waits; in_ready_o drops only when both hold replies. flash_base is written through
// cfg_we_i/cfg_wdata_i and must only change while the block is idle.
module firmware_update_receiver #(
  parameter int unsigned OFFSET_BITS = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [23:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fur_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fur_pkg::out_item_t  out_item_o
);
  import fur_pkg::*;

  localparam int unsigned ExtW = (OFFSET_BITS > AddrW) ? OFFSET_BITS : AddrW;

  // Session state
  logic [AddrW-1:0]       flash_base_q;
  logic                   session_open_q, session_open_d;
  logic                   image_ended_q, image_ended_d;
  logic [1:0]             active_bank_q, active_bank_d;
  logic [OFFSET_BITS-1:0] write_offset_q, write_offset_d;
  logic [ChunksW-1:0]     chunks_written_q, chunks_written_d;
  logic [31:0]            crc_zero_q, crc_zero_d;
  logic [31:0]            crc_one_q, crc_one_d;

  // Output stage
  logic      out_valid_q;
  logic      skid_valid_q;
  out_item_t out_item_q;
  out_item_t skid_item_q;

  logic        push_w, pop_w;
  logic [31:0] crc_chunk_w;
  logic [ExtW-1:0] offset_ext_w;
  out_item_t   res_w;

  assign push_w = in_valid_i && in_ready_o;
  assign pop_w  = out_valid_q && out_ready_i;

  fur_crc_unit u_crc (
    .crc_i        (crc_zero_q),
    .chunk_low_i  (in_item_i.chunk_low),
    .chunk_high_i (in_item_i.chunk_high),
    .chunk_count_i(in_item_i.chunk_count),
    .crc_o        (crc_chunk_w)
  );

  assign offset_ext_w = ExtW'(write_offset_q);

  // Command decode and next state
  always_comb begin
    session_open_d   = session_open_q;
    image_ended_d    = image_ended_q;
    active_bank_d    = active_bank_q;
    write_offset_d   = write_offset_q;
    chunks_written_d = chunks_written_q;
    crc_zero_d       = crc_zero_q;
    crc_one_d        = crc_one_q;
    res_w            = '0;

    unique case (in_item_i.operation)
      OP_START: begin
        session_open_d   = 1'b1;
        image_ended_d    = 1'b0;
        write_offset_d   = '0;
        chunks_written_d = '0;
        crc_zero_d       = CrcStart;
        crc_one_d        = CrcStart;
        res_w.reply_kind = RK_SESSION_ACK;
        res_w.seq_out    = in_item_i.seq_in;
      end
      OP_BANK: begin
        if (in_item_i.bank_request < BankLimit) begin
          active_bank_d = in_item_i.bank_request[1:0];
          res_w.bank_ok = 1'b1;
        end
        res_w.reply_kind = RK_BANK_REPLY;
        res_w.seq_out    = in_item_i.seq_in;
      end
      OP_CHUNK: begin
        if (!session_open_q || (in_item_i.chunk_count > CountW'(MaxChunkBytes))) begin
          res_w.reply_kind = RK_REFUSED;
          res_w.seq_out    = in_item_i.seq_in;
        end else begin
          if (active_bank_q == 2'd0) begin
            crc_zero_d = crc_chunk_w;
          end
          if (!image_ended_q) begin
            res_w.flash_address = flash_base_q + offset_ext_w[AddrW-1:0];
            res_w.erase_now     = ((write_offset_q[11:0] & SectorMask) == 12'd0);
            if ((in_item_i.chunk_count == LongChunk) && (chunks_written_q < LimitLong)) begin
              res_w.program_now   = 1'b1;
              res_w.program_count = LongChunk;
              res_w.program_low   = in_item_i.chunk_low;
              res_w.program_high  = in_item_i.chunk_high;
              // First chunk: boot marker byte is left erased
              if ((chunks_written_q == '0) && (in_item_i.chunk_high[7:0] == PatchMatch)) begin
                res_w.program_high[7:0] = PatchValue;
              end
              chunks_written_d = chunks_written_q + ChunksW'(1);
            end else if ((in_item_i.chunk_count == ShortChunk) &&
                         (chunks_written_q < LimitShort)) begin
              res_w.program_now   = 1'b1;
              res_w.program_count = ShortChunk;
              res_w.program_low   = {32'd0, in_item_i.chunk_low[31:0]};
              chunks_written_d    = chunks_written_q + ChunksW'(1);
              image_ended_d       = 1'b1;
            end
            res_w.reply_kind = RK_CHUNK_ACK;
            res_w.seq_out    = in_item_i.seq_in;
          end
          write_offset_d = write_offset_q + OFFSET_BITS'(in_item_i.chunk_count);
        end
      end
      OP_COMMIT: begin
        unique case (active_bank_q)
          2'd0: res_w.commit_fail = !((in_item_i.crc_first == in_item_i.crc_second) &&
                                      (in_item_i.crc_first == crc_zero_q));
          2'd1: res_w.commit_fail = !((in_item_i.crc_first == crc_one_q) &&
                                      (in_item_i.crc_second == crc_zero_q));
          default: res_w.commit_fail = 1'b1;
        endcase
        res_w.reply_kind = RK_COMMIT;
        res_w.seq_out    = in_item_i.seq_in;
      end
      default: res_w = '0;
    endcase

    res_w.image_done = image_ended_d;
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flash_base_q <= '0;
    end else if (cfg_we_i) begin
      flash_base_q <= cfg_wdata_i;
    end
  end

  // Session state update on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      session_open_q   <= 1'b0;
      image_ended_q    <= 1'b0;
      active_bank_q    <= '0;
      write_offset_q   <= '0;
      chunks_written_q <= '0;
      crc_zero_q       <= CrcStart;
      crc_one_q        <= CrcStart;
    end else if (push_w) begin
      session_open_q   <= session_open_d;
      image_ended_q    <= image_ended_d;
      active_bank_q    <= active_bank_d;
      write_offset_q   <= write_offset_d;
      chunks_written_q <= chunks_written_d;
      crc_zero_q       <= crc_zero_d;
      crc_one_q        <= crc_one_d;
    end
  end

  // Output register and skid stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop_w) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push_w;
      end
    end else if (push_w) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop_w) begin
      if (skid_valid_q) begin
        out_item_q <= skid_item_q;
      end else if (push_w) begin
        out_item_q <= res_w;
      end
    end else if (push_w) begin
      skid_item_q <= res_w;
    end
  end

  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

### rtl/fur_checker.sv
// Port-level checker for the firmware update receiver, bound to the top level.
`default_nettype none

module fur_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input fur_pkg::out_item_t out_item_o
);
  import fur_pkg::*;

  // A stalled reply holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("reply changed while stalled");

  // Programming only comes with a chunk ack and a legal length
  a_prog_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.program_now |->
      (out_item_o.reply_kind == RK_CHUNK_ACK) &&
      ((out_item_o.program_count == ShortChunk) || (out_item_o.program_count == LongChunk)))
    else $error("program command outside a chunk ack");

  // Flash commands stay quiet on every other reply
  a_flash_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.reply_kind != RK_CHUNK_ACK) |->
      !out_item_o.erase_now && !out_item_o.program_now && (out_item_o.flash_address == '0))
    else $error("flash command on a non-chunk reply");

  // A silent result or a short program carries no sequence number or else the image end flag
  a_none_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_item_o.reply_kind == RK_NONE) ||
                    (out_item_o.program_now && (out_item_o.program_count == ShortChunk))) |->
      (out_item_o.seq_out == '0) || out_item_o.image_done)
    else $error("silent reply with sequence or short program without image end");

endmodule

bind firmware_update_receiver fur_checker u_fur_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_item_o (out_item_o)
);

`default_nettype wire

### tb/firmware_update_receiver_tb.sv
// Self-checking testbench for the firmware update receiver: directed, random and stress tests.
module firmware_update_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fur_pkg::*;

  localparam int CycleLimit    = 1_000_000;
  localparam int HoldOffCycles = 80;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [23:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_item_t    in_item_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_item_o;

  firmware_update_receiver u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the download state, updated as each command transaction is accepted
  logic [23:0] flash_base_q = '0;
  logic        session_q    = 1'b0;
  logic        ended_q      = 1'b0;
  logic [1:0]  bank_q       = '0;
  logic [23:0] offset_q     = '0;
  logic [13:0] chunks_q     = '0;
  logic [31:0] crc_zero_q   = CrcStart;
  logic [31:0] crc_one_q    = CrcStart;

  out_item_t pending_replies[$];
  out_item_t reply_want;

  int mismatches      = 0;
  int commands_sent   = 0;
  int replies_checked = 0;
  int chunk_acks      = 0;
  int commits_seen    = 0;
  int cfg_writes      = 0;
  int cycle_count     = 0;

  // Sender burst control
  bit gaps_on    = 1'b1;
  int burst_left = 0;

  // Receiver stall control
  int hold_asks        = 0;
  int hold_seen        = 0;
  int hold_left        = 0;
  int stall_mode       = 0;
  int stall_phase_left = 0;

  // Reflected CRC-32 over one byte, no final xor
  function automatic logic [31:0] crc32_feed(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] v;
    v = {24'd0, crc[7:0] ^ b};
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ CrcPoly) : (v >> 1);
    end
    return (crc >> 8) ^ v;
  endfunction

  // Reply for one command; advances the shadow state
  function automatic out_item_t download_reply(input in_item_t c);
    out_item_t    r;
    logic [127:0] bytes;
    logic         fail;
    r     = '0;
    bytes = {c.chunk_high, c.chunk_low};
    fail  = 1'b1;
    case (c.operation)
      OP_START: begin
        session_q  = 1'b1;
        offset_q   = '0;
        chunks_q   = '0;
        ended_q    = 1'b0;
        crc_zero_q = CrcStart;
        crc_one_q  = CrcStart;
        r.reply_kind = RK_SESSION_ACK;
        r.seq_out    = c.seq_in;
      end
      OP_BANK: begin
        if (c.bank_request < BankLimit) begin
          bank_q    = c.bank_request[1:0];
          r.bank_ok = 1'b1;
        end
        r.reply_kind = RK_BANK_REPLY;
        r.seq_out    = c.seq_in;
      end
      OP_CHUNK: begin
        if (!session_q || c.chunk_count > MaxChunkBytes) begin
          r.reply_kind = RK_REFUSED;
          r.seq_out    = c.seq_in;
        end else begin
          // only bank 0 data runs through the CRC
          if (bank_q == 2'd0) begin
            for (int i = 0; i < c.chunk_count; i++) begin
              crc_zero_q = crc32_feed(crc_zero_q, bytes[8*i +: 8]);
            end
          end
          if (!ended_q) begin
            r.flash_address = flash_base_q + offset_q;
            r.erase_now     = (offset_q[11:0] & SectorMask) == '0;
            if (c.chunk_count == LongChunk && chunks_q < LimitLong) begin
              r.program_now   = 1'b1;
              r.program_count = LongChunk;
              r.program_low   = c.chunk_low;
              r.program_high  = c.chunk_high;
              // first long chunk: marker byte is replaced in flash only
              if (chunks_q == '0 && c.chunk_high[7:0] == PatchMatch) begin
                r.program_high[7:0] = PatchValue;
              end
              chunks_q = chunks_q + 1'b1;
            end else if (c.chunk_count == ShortChunk && chunks_q < LimitShort) begin
              r.program_now   = 1'b1;
              r.program_count = ShortChunk;
              r.program_low   = {32'd0, c.chunk_low[31:0]};
              chunks_q = chunks_q + 1'b1;
              ended_q  = 1'b1;
            end
            r.reply_kind = RK_CHUNK_ACK;
            r.seq_out    = c.seq_in;
          end
          offset_q = offset_q + c.chunk_count;
        end
      end
      default: begin
        if (bank_q == 2'd0) begin
          fail = !(c.crc_first == c.crc_second && c.crc_first == crc_zero_q);
        end else if (bank_q == 2'd1) begin
          fail = !(c.crc_first == crc_one_q && c.crc_second == crc_zero_q);
        end
        r.commit_fail = fail;
        r.reply_kind  = RK_COMMIT;
        r.seq_out     = c.seq_in;
      end
    endcase
    r.image_done = ended_q;
    return r;
  endfunction

  // Command of the given kind, every other field random
  function automatic in_item_t command(input op_e op);
    in_item_t c;
    c.operation    = op;
    c.seq_in       = 8'($urandom);
    c.bank_request = 8'($urandom);
    c.chunk_count  = 5'($urandom);
    c.chunk_low    = {$urandom, $urandom};
    c.chunk_high   = {$urandom, $urandom};
    c.crc_first    = $urandom;
    c.crc_second   = $urandom;
    return c;
  endfunction

  function automatic in_item_t chunk_command(input logic [4:0] count);
    in_item_t c;
    c = command(OP_CHUNK);
    c.chunk_count = count;
    return c;
  endfunction

  function automatic in_item_t bank_command(input logic [7:0] bank);
    in_item_t c;
    c = command(OP_BANK);
    c.bank_request = bank;
    return c;
  endfunction

  // Commit carrying the words that pass for bank 0 or 1, or a corrupted copy
  function automatic in_item_t commit_command(input bit good);
    in_item_t c;
    c = command(OP_COMMIT);
    c.crc_first  = (bank_q == 2'd1) ? crc_one_q : crc_zero_q;
    c.crc_second = crc_zero_q;
    if (!good) begin
      if ($urandom_range(0, 1)) c.crc_first ^= 32'(1) << $urandom_range(0, 31);
      else                      c.crc_second ^= 32'(1) << $urandom_range(0, 31);
    end
    return c;
  endfunction

  function automatic in_item_t random_command();
    in_item_t c;
    c = command(op_e'($urandom_range(0, 3)));
    if ($urandom_range(0, 3) != 0) c.bank_request = 8'($urandom_range(0, 3));
    c.chunk_count = ($urandom_range(0, 5) == 0) ? 5'($urandom_range(17, 31))
                                                 : 5'($urandom_range(0, 16));
    return c;
  endfunction

  // Drive one command transaction and wait for its acceptance
  task automatic send_command(input in_item_t cmd);
    in_item_i  <= cmd;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_replies.push_back(download_reply(cmd));
    commands_sent++;
    if (gaps_on) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        burst_left = $urandom_range(0, 15);
      end
    end
  endtask

  // Stop offering and wait until every reply is back
  task automatic drain_replies();
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_flash_base(input logic [23:0] base);
    drain_replies();
    cfg_wdata_i <= base;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    flash_base_q = base;
    cfg_writes++;
  endtask

  // Special cases one by one: no session, bank limits, oversize chunks, marker byte, image end
  task automatic test_directed_cases();
    in_item_t c;
    write_flash_base(24'h000000);
    send_command(chunk_command(LongChunk));
    c = command(OP_COMMIT);
    c.seq_in     = 8'h00;
    c.crc_first  = CrcStart;
    c.crc_second = CrcStart;
    send_command(c);
    c.crc_second = '0;
    send_command(c);
    send_command(bank_command(8'hFF));
    send_command(bank_command(BankLimit));
    send_command(bank_command(8'd2));
    send_command(commit_command(1'b1));
    send_command(bank_command(8'd1));
    send_command(commit_command(1'b1));
    send_command(bank_command(8'd0));
    c = command(OP_START);
    c.seq_in = 8'hFF;
    send_command(c);
    send_command(chunk_command(5'd17));
    send_command(chunk_command(5'd31));
    c = chunk_command(LongChunk);
    c.chunk_high[7:0] = PatchMatch;
    send_command(c);
    c = chunk_command(LongChunk);
    c.chunk_high[7:0] = PatchMatch;
    send_command(c);
    send_command(chunk_command(5'd7));
    send_command(chunk_command(5'd0));
    send_command(bank_command(8'd1));
    send_command(chunk_command(LongChunk));
    send_command(bank_command(8'd0));
    send_command(chunk_command(ShortChunk));
    send_command(chunk_command(LongChunk));
    send_command(chunk_command(ShortChunk));
    send_command(commit_command(1'b1));
    send_command(command(OP_START));
    c = chunk_command(LongChunk);
    c.chunk_low  = '1;
    c.chunk_high = '1;
    send_command(c);
    c.chunk_low  = '0;
    c.chunk_high = '0;
    send_command(c);
    drain_replies();
  endtask

  // Image past one 4 KiB sector at the top of the address space
  task automatic test_sector_wrap();
    write_flash_base(24'hFFFFFF);
    send_command(command(OP_START));
    send_command(bank_command(8'd0));
    repeat (258) send_command(chunk_command(LongChunk));
    send_command(chunk_command(ShortChunk));
    send_command(commit_command(1'b1));
    drain_replies();
  endtask

  // Mostly well-formed downloads with random data, some noise in between
  task automatic test_random_downloads(input int target);
    in_item_t c;
    int       first;
    int       n;
    first = commands_sent;
    write_flash_base(24'($urandom));
    while (commands_sent - first < target) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 6)) send_command(random_command());
      end else begin
        if ($urandom_range(0, 9) != 0) send_command(command(OP_START));
        send_command(bank_command(($urandom_range(0, 9) < 7) ? 8'd0 :
                                  8'($urandom_range(1, 4))));
        n = $urandom_range(1, 20);
        for (int i = 0; i < n; i++) begin
          c = chunk_command(($urandom_range(0, 5) == 0) ? 5'($urandom_range(0, 16))
                                                         : LongChunk);
          if (i == 0 && $urandom_range(0, 1)) c.chunk_high[7:0] = PatchMatch;
          send_command(c);
        end
        if ($urandom_range(0, 4) != 0) send_command(chunk_command(ShortChunk));
        if ($urandom_range(0, 3) == 0) send_command(random_command());
        send_command(commit_command($urandom_range(0, 3) != 0));
      end
    end
    drain_replies();
  endtask

  // Receiver holds off while the sender keeps pushing, so the input stalls
  task automatic test_output_backpressure();
    gaps_on = 1'b0;
    hold_asks++;
    send_command(command(OP_START));
    send_command(bank_command(8'd0));
    repeat (30) send_command(chunk_command(LongChunk));
    send_command(chunk_command(ShortChunk));
    send_command(commit_command(1'b1));
    gaps_on = 1'b1;
    drain_replies();
  endtask

  // Receiver ready: long hold-off on request, otherwise phases of random stalls
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HoldOffCycles;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      if (stall_phase_left == 0) begin
        stall_mode       = $urandom_range(0, 3);
        stall_phase_left = $urandom_range(4, 48);
      end else begin
        stall_phase_left--;
      end
      case (stall_mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= $urandom_range(0, 1);
        2:       out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= (stall_phase_left % 3 != 0);
      endcase
    end
  end

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare each reply transaction against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_replies.size() == 0) begin
        $error("reply transaction with nothing pending");
        mismatches++;
      end else begin
        reply_want = pending_replies.pop_front();
        check_field("reply_kind", reply_want.reply_kind, out_item_o.reply_kind);
        check_field("seq_out", reply_want.seq_out, out_item_o.seq_out);
        check_field("bank_ok", reply_want.bank_ok, out_item_o.bank_ok);
        check_field("commit_fail", reply_want.commit_fail, out_item_o.commit_fail);
        check_field("erase_now", reply_want.erase_now, out_item_o.erase_now);
        check_field("program_now", reply_want.program_now, out_item_o.program_now);
        check_field("flash_address", reply_want.flash_address, out_item_o.flash_address);
        check_field("program_count", reply_want.program_count, out_item_o.program_count);
        check_field("program_low", reply_want.program_low, out_item_o.program_low);
        check_field("program_high", reply_want.program_high, out_item_o.program_high);
        check_field("image_done", reply_want.image_done, out_item_o.image_done);
        replies_checked++;
        if (reply_want.reply_kind == RK_CHUNK_ACK) chunk_acks++;
        if (reply_want.reply_kind == RK_COMMIT) commits_seen++;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_cases();
    test_sector_wrap();
    test_random_downloads(50);
    test_random_downloads(50);
    test_random_downloads(50);
    test_output_backpressure();
    repeat (8) @(posedge clk_i);
    $display("Run covered %0d commands and %0d checked replies (%0d chunk acks, %0d commits),",
             commands_sent, replies_checked, chunk_acks, commits_seen);
    $display("with %0d flash base settings, a sector crossing and a long output hold-off.",
             cfg_writes);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
